// ===== rtl/chgw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chgw_pkg
// Shared status type and status codes of the gift-wrapping convex hull block.
// ----------------------------------------------------------------------------
package chgw_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_EMPTY   = 2'd1;
  localparam status_t STATUS_DROPPED = 2'd2;
  localparam status_t STATUS_CUT     = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/convex_hull_gift_wrap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap
// Jarvis march convex hull over a point set loaded one point per request.
//
// Input channel: a request (point_x_i, point_y_i, last_point_i) is taken on
// a rising edge with start high and busy low. Points are stored in a local
// memory of MAX_POINTS entries; further points are dropped and flagged.
// A point without last_point_i gives no result and leaves busy low.
// After a last point with two or more stored points busy rises and the
// hull is computed with one shared multiplier under a sequencer. A start
// search reads every stored point. Each hull step then scans every point:
// the first, or any while the candidate is still the current point, is
// taken without a multiply; others get a cross product, and a collinear
// one a length comparison. Emission then reads out each hull point in
// turn. Results leave on hull_valid_o, one cycle each, with last_hull_o on
// the final one; the receiver cannot stall, so none is held back. Fewer
// than two stored points give one empty result in the cycle after the
// accepting edge. Reset empties the store and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module convex_hull_gift_wrap #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic                         last_point_i,
  output      logic                         hull_valid_o,
  output      logic signed [COORD_BITS-1:0] hull_x_o,
  output      logic signed [COORD_BITS-1:0] hull_y_o,
  output      logic                         last_hull_o,
  output      chgw_pkg::status_t            status_o
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SF_RD  = 5'd1;
  localparam logic [4:0] ST_SF_CMP = 5'd2;
  localparam logic [4:0] ST_W_PUSH = 5'd3;
  localparam logic [4:0] ST_C_RD   = 5'd4;
  localparam logic [4:0] ST_C_DIF  = 5'd5;
  localparam logic [4:0] ST_C_X0   = 5'd6;
  localparam logic [4:0] ST_C_X1   = 5'd7;
  localparam logic [4:0] ST_C_XC   = 5'd8;
  localparam logic [4:0] ST_C_L0   = 5'd9;
  localparam logic [4:0] ST_C_L1   = 5'd10;
  localparam logic [4:0] ST_C_L2   = 5'd11;
  localparam logic [4:0] ST_C_L3   = 5'd12;
  localparam logic [4:0] ST_C_LC   = 5'd13;
  localparam logic [4:0] ST_C_NXT  = 5'd14;
  localparam logic [4:0] ST_W_NEXT = 5'd15;
  localparam logic [4:0] ST_E_RD   = 5'd16;
  localparam logic [4:0] ST_E_OUT  = 5'd17;

  // memories
  logic [2*CB-1:0] pt_mem   [MAX_POINTS];
  logic [2*CB-1:0] hull_mem [MAX_POINTS];
  logic [2*CB-1:0] rd_data_q;
  logic [2*CB-1:0] hrd_q;

  // control state
  logic [4:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic          cut_q, cut_d;
  logic [CW-1:0] hull_len_q, hull_len_d;
  logic [CW-1:0] emit_idx_q, emit_idx_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] cur_idx_q, cur_idx_d;
  logic [IW-1:0] cand_idx_q, cand_idx_d;
  logic [IW-1:0] start_idx_q, start_idx_d;
  logic          hull_valid_q, hull_valid_d;

  // datapath
  logic signed [CB-1:0] hx_q, hx_d, hy_q, hy_d;
  logic signed [CB-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [CB-1:0] px_q, px_d, py_q, py_d;
  logic signed [DW-1:0] d1x_q, d1x_d, d1y_q, d1y_d;
  logic signed [DW-1:0] d2x_q, d2x_d, d2y_q, d2y_d;
  logic signed [PW-1:0] prod_q, prod_d, acc_q, acc_d, accb_q, accb_d;
  logic signed [CB-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic                 out_last_q, out_last_d;
  chgw_pkg::status_t    out_st_q, out_st_d;

  logic                 accept;
  logic [CW-1:0]        count_next;
  logic [IW-1:0]        last_idx;
  logic signed [CB-1:0] rd_x, rd_y, hr_x, hr_y;
  logic signed [DW-1:0] dx_rd, dy_rd;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_res;
  logic                 emit_last;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign count_next = (count_q < CW'(MAX_POINTS)) ? count_q + CW'(1) : count_q;
  assign last_idx   = IW'(count_q - CW'(1));
  assign emit_last  = (emit_idx_q == hull_len_q - CW'(1));

  assign rd_x  = $signed(rd_data_q[CB-1:0]);
  assign rd_y  = $signed(rd_data_q[2*CB-1:CB]);
  assign hr_x  = $signed(hrd_q[CB-1:0]);
  assign hr_y  = $signed(hrd_q[2*CB-1:CB]);
  assign dx_rd = DW'(rd_x) - DW'(hx_q);
  assign dy_rd = DW'(rd_y) - DW'(hy_q);

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_C_X1: begin mul_a = d1y_q; mul_b = d2x_q; end
      ST_C_L0: begin mul_a = d2x_q; mul_b = d2x_q; end
      ST_C_L1: begin mul_a = d2y_q; mul_b = d2y_q; end
      ST_C_L2: begin mul_a = d1x_q; mul_b = d1x_q; end
      ST_C_L3: begin mul_a = d1y_q; mul_b = d1y_q; end
      default: begin mul_a = d1x_q; mul_b = d2y_q; end
    endcase
  end

  assign mul_res = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    dropped_d    = dropped_q;
    cut_d        = cut_q;
    hull_len_d   = hull_len_q;
    emit_idx_d   = emit_idx_q;
    idx_d        = idx_q;
    cur_idx_d    = cur_idx_q;
    cand_idx_d   = cand_idx_q;
    start_idx_d  = start_idx_q;
    hull_valid_d = 1'b0;
    hx_d         = hx_q;
    hy_d         = hy_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    px_d         = px_q;
    py_d         = py_q;
    d1x_d        = d1x_q;
    d1y_d        = d1y_q;
    d2x_d        = d2x_q;
    d2y_d        = d2y_q;
    prod_d       = mul_res;
    acc_d        = acc_q;
    accb_d       = accb_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_last_d   = out_last_q;
    out_st_d     = out_st_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d   = count_next;
          dropped_d = dropped_q || (count_q >= CW'(MAX_POINTS));
          if (last_point_i) begin
            if (count_next < CW'(2)) begin
              hull_valid_d = 1'b1;
              out_x_d      = '0;
              out_y_d      = '0;
              out_last_d   = 1'b1;
              out_st_d     = chgw_pkg::STATUS_EMPTY;
              count_d      = '0;
              dropped_d    = 1'b0;
            end else begin
              idx_d      = '0;
              hull_len_d = '0;
              state_d    = ST_SF_RD;
            end
          end
        end
      end
      ST_SF_RD: state_d = ST_SF_CMP;
      ST_SF_CMP: begin
        // largest x, smallest y on a tie, first copy kept
        if (idx_q == '0 || rd_x > hx_q || (rd_x == hx_q && rd_y < hy_q)) begin
          hx_d        = rd_x;
          hy_d        = rd_y;
          cur_idx_d   = idx_q;
          start_idx_d = idx_q;
        end
        if (idx_q == last_idx) begin
          state_d = ST_W_PUSH;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_SF_RD;
        end
      end
      ST_W_PUSH: begin
        hull_len_d = hull_len_q + CW'(1);
        idx_d      = '0;
        state_d    = ST_C_RD;
      end
      ST_C_RD: state_d = ST_C_DIF;
      ST_C_DIF: begin
        px_d  = rd_x;
        py_d  = rd_y;
        d2x_d = dx_rd;
        d2y_d = dy_rd;
        if (idx_q == '0 || cand_idx_q == cur_idx_q) begin
          cand_idx_d = idx_q;
          cx_d       = rd_x;
          cy_d       = rd_y;
          d1x_d      = dx_rd;
          d1y_d      = dy_rd;
          state_d    = ST_C_NXT;
        end else begin
          state_d = ST_C_X0;
        end
      end
      ST_C_X0: state_d = ST_C_X1;
      ST_C_X1: begin
        acc_d   = prod_q;
        state_d = ST_C_XC;
      end
      ST_C_XC: begin
        // negative cross product takes the point, collinear goes to lengths
        if (acc_q < prod_q) begin
          cand_idx_d = idx_q;
          cx_d       = px_q;
          cy_d       = py_q;
          d1x_d      = d2x_q;
          d1y_d      = d2y_q;
          state_d    = ST_C_NXT;
        end else if (acc_q == prod_q) begin
          state_d = ST_C_L0;
        end else begin
          state_d = ST_C_NXT;
        end
      end
      ST_C_L0: state_d = ST_C_L1;
      ST_C_L1: begin
        acc_d   = prod_q;
        state_d = ST_C_L2;
      end
      ST_C_L2: begin
        acc_d   = acc_q + prod_q;
        state_d = ST_C_L3;
      end
      ST_C_L3: begin
        accb_d  = prod_q;
        state_d = ST_C_LC;
      end
      ST_C_LC: begin
        if (acc_q > accb_q + prod_q) begin
          cand_idx_d = idx_q;
          cx_d       = px_q;
          cy_d       = py_q;
          d1x_d      = d2x_q;
          d1y_d      = d2y_q;
        end
        state_d = ST_C_NXT;
      end
      ST_C_NXT: begin
        if (idx_q == last_idx) begin
          state_d = ST_W_NEXT;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_C_RD;
        end
      end
      ST_W_NEXT: begin
        cur_idx_d  = cand_idx_q;
        hx_d       = cx_q;
        hy_d       = cy_q;
        emit_idx_d = '0;
        if (cand_idx_q == start_idx_q) begin
          cut_d   = 1'b0;
          state_d = ST_E_RD;
        end else if (hull_len_q >= CW'(MAX_POINTS)) begin
          cut_d   = 1'b1;
          state_d = ST_E_RD;
        end else begin
          state_d = ST_W_PUSH;
        end
      end
      ST_E_RD: state_d = ST_E_OUT;
      ST_E_OUT: begin
        hull_valid_d = 1'b1;
        out_x_d      = hr_x;
        out_y_d      = hr_y;
        out_last_d   = emit_last;
        out_st_d     = cut_q     ? chgw_pkg::STATUS_CUT :
                       dropped_q ? chgw_pkg::STATUS_DROPPED : chgw_pkg::STATUS_OK;
        if (emit_last) begin
          count_d   = '0;
          dropped_d = 1'b0;
          state_d   = ST_IDLE;
        end else begin
          emit_idx_d = emit_idx_q + CW'(1);
          state_d    = ST_E_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      dropped_q    <= 1'b0;
      cut_q        <= 1'b0;
      hull_len_q   <= '0;
      emit_idx_q   <= '0;
      idx_q        <= '0;
      cur_idx_q    <= '0;
      cand_idx_q   <= '0;
      start_idx_q  <= '0;
      hull_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      dropped_q    <= dropped_d;
      cut_q        <= cut_d;
      hull_len_q   <= hull_len_d;
      emit_idx_q   <= emit_idx_d;
      idx_q        <= idx_d;
      cur_idx_q    <= cur_idx_d;
      cand_idx_q   <= cand_idx_d;
      start_idx_q  <= start_idx_d;
      hull_valid_q <= hull_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hx_q       <= hx_d;
    hy_q       <= hy_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    px_q       <= px_d;
    py_q       <= py_d;
    d1x_q      <= d1x_d;
    d1y_q      <= d1y_d;
    d2x_q      <= d2x_d;
    d2y_q      <= d2y_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    accb_q     <= accb_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_last_q <= out_last_d;
    out_st_q   <= out_st_d;
  end

  // point store: written while idle, read at the scan index
  always_ff @(posedge clk_i) begin
    if (accept && (count_q < CW'(MAX_POINTS))) begin
      pt_mem[count_q[IW-1:0]] <= {point_y_i, point_x_i};
    end
    rd_data_q <= pt_mem[idx_q];
  end

  // hull list: one entry per walk step
  always_ff @(posedge clk_i) begin
    if (state_q == ST_W_PUSH) begin
      hull_mem[hull_len_q[IW-1:0]] <= {hy_q, hx_q};
    end
    hrd_q <= hull_mem[emit_idx_q[IW-1:0]];
  end

  assign hull_valid_o = hull_valid_q;
  assign hull_x_o     = out_x_q;
  assign hull_y_o     = out_y_q;
  assign last_hull_o  = out_last_q;
  assign status_o     = out_st_q;

endmodule
`default_nettype wire
